@@ hw/rtl/tuc_pkg.sv @@
// Shared types, constants and functions for the texture unswizzle / color expand block.
// Used by every RTL file and the checker; no dependencies.
`timescale 1ns / 1ps

package tuc_pkg;

  localparam int SRC_W      = 32;
  localparam int DATA_W     = 32;
  localparam int OFS_W      = 23;
  localparam int NB_W       = 3;
  localparam int FMT_W      = 3;
  localparam int DIM_W      = 11;
  localparam int PITCH_W    = 13;
  localparam int STRIDE_W   = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int TILE_BYTES = 16;
  localparam int TILE_ROWS  = 8;
  localparam int TW16       = TILE_BYTES / 2;
  localparam int TW32       = TILE_BYTES / 4;
  localparam int TW_IDX4    = TILE_BYTES * 2;
  localparam int TW_IDX8    = TILE_BYTES;

  localparam logic [FMT_W-1:0] FMT_RGB565   = 3'd0;
  localparam logic [FMT_W-1:0] FMT_ARGB1555 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_ARGB4444 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_RGBA8888 = 3'd3;
  localparam logic [FMT_W-1:0] FMT_INDEX4   = 3'd4;
  localparam logic [FMT_W-1:0] FMT_INDEX8   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWIZZLED     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_PITCH = 3'd4;

  localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 11'd1;
  localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 11'd1;
  localparam logic [PITCH_W-1:0] RST_SOURCE_PITCH = 13'd16;

  localparam logic [NB_W-1:0] NB_INDEX = 3'd1;
  localparam logic [NB_W-1:0] NB_RGB   = 3'd3;
  localparam logic [NB_W-1:0] NB_RGBA  = 3'd4;

  typedef struct packed {
    logic [FMT_W-1:0]   fmt;
    logic               swizzled;
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic [PITCH_W-1:0] source_pitch;
  } tuc_cfg_t;

  typedef struct packed {
    logic [SRC_W-1:0]    src_element;
    logic [FMT_W-1:0]    fmt;
    logic [STRIDE_W-1:0] stride;
    logic [NB_W-1:0]     nb;
    logic [OFS_W-1:0]    dst_base;
    logic                last;
  } tuc_beat_t;

  function automatic logic [NB_W-1:0] tuc_bytes(input logic [FMT_W-1:0] fmt);
    case (fmt)
      FMT_RGB565:   return NB_RGB;
      FMT_ARGB1555: return NB_RGBA;
      FMT_ARGB4444: return NB_RGBA;
      FMT_RGBA8888: return NB_RGBA;
      default:      return NB_INDEX;
    endcase
  endfunction

  function automatic logic [STRIDE_W-1:0] tuc_stride(input logic [FMT_W-1:0] fmt,
                                                     input logic [PITCH_W-1:0] pitch);
    logic [STRIDE_W-1:0] p;
    p = STRIDE_W'(pitch);
    case (fmt)
      FMT_RGB565:   return (p + (p << 1)) >> 1;
      FMT_ARGB1555: return p << 1;
      FMT_ARGB4444: return p << 1;
      default:      return p;
    endcase
  endfunction

  // scale an element count by the bytes per element (1, 3 or 4)
  function automatic logic [OFS_W-1:0] tuc_scale(input logic [OFS_W-1:0] v,
                                                 input logic [NB_W-1:0] nb);
    case (nb)
      NB_RGB:  return v + (v << 1);
      NB_RGBA: return v << 2;
      default: return v;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] tuc_expand(input logic [FMT_W-1:0] fmt,
                                                   input logic [SRC_W-1:0] e);
    logic [7:0] s0;
    logic [7:0] s1;
    s0 = e[7:0];
    s1 = e[15:8];
    case (fmt)
      FMT_RGB565:
        return {8'h00, s1[7:3], 3'b000, s1[2:0], s0[7:5], 2'b00, s0[4:0], 3'b000};
      FMT_ARGB1555:
        return {{8{s1[7]}}, s1[6:2], 3'b000, s1[1:0], s0[7:5], 3'b000, s0[4:0], 3'b000};
      FMT_ARGB4444:
        return {s1[7:4], 4'h0, s1[3:0], 4'h0, s0[7:4], 4'h0, s0[3:0], 4'h0};
      FMT_RGBA8888:
        return e;
      FMT_INDEX4:
        return {24'h000000, s0[3:0], s0[7:4]};
      default:
        return {24'h000000, s0};
    endcase
  endfunction

endpackage

@@ hw/rtl/tuc_if.sv @@
// Valid/ready stream interfaces for the source element and result channels.
// Depends on tuc_pkg for field widths.
`timescale 1ns / 1ps

interface tuc_in_if;
  import tuc_pkg::*;
  logic             valid;
  logic             ready;
  logic [SRC_W-1:0] src_element;
  modport source(output valid, output src_element, input ready);
  modport sink(input valid, input src_element, output ready);
endinterface

interface tuc_out_if;
  import tuc_pkg::*;
  logic              valid;
  logic              ready;
  logic [OFS_W-1:0]  dst_offset;
  logic [DATA_W-1:0] dst_data;
  logic [NB_W-1:0]   dst_bytes;
  logic              last_of_image;
  modport source(output valid, output dst_offset, output dst_data, output dst_bytes,
                 output last_of_image, input ready);
  modport sink(input valid, input dst_offset, input dst_data, input dst_bytes,
               input last_of_image, output ready);
endinterface

@@ hw/rtl/texture_unswizzle_color_expand.sv @@
// Texture unswizzle and color expand, top level.
// Depends on tuc_pkg, tuc_if, tuc_cfg_regs, tuc_walker and tuc_emit.
//
// Takes one source texel element per beat, in source order, and returns the byte offset
// of that element in the linear destination image with its expanded bytes, byte count
// and an end-of-image flag. Throughput is one element per clock unless the result side
// stalls; each element passes the input stage register, then the output register, held
// longer on a stall. Cycle time is set by the position walker loop: counter compares
// plus one pitch-by-rows multiply for the band step. Configuration is written through
// cfg_we/cfg_idx/cfg_data, by the user only while no beat is in flight (not enforced).
`timescale 1ns / 1ps

module texture_unswizzle_color_expand #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tuc_in_if.sink                         in_stream,
  tuc_out_if.source                      out_stream,
  input  logic                           cfg_we,
  input  logic [tuc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tuc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tuc_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 64);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  tuc_cfg_t      cfg;
  tuc_beat_t     beat;
  logic          beat_valid;
  logic          beat_ready;
  logic          in_ready;
  logic [WW-1:0] beat_col;
  logic [HW-1:0] beat_row;

  tuc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  tuc_walker #(
    .WW         (WW),
    .HW         (HW),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_stream.valid),
    .in_ready   (in_ready),
    .in_element (in_stream.src_element),
    .beat_valid (beat_valid),
    .beat_ready (beat_ready),
    .beat       (beat),
    .beat_col   (beat_col),
    .beat_row   (beat_row)
  );

  tuc_emit #(
    .WW (WW),
    .HW (HW)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (beat_valid),
    .beat_ready (beat_ready),
    .beat       (beat),
    .beat_col   (beat_col),
    .beat_row   (beat_row),
    .out_valid  (out_stream.valid),
    .out_ready  (out_stream.ready),
    .out_offset (out_stream.dst_offset),
    .out_data   (out_stream.dst_data),
    .out_bytes  (out_stream.dst_bytes),
    .out_last   (out_stream.last_of_image)
  );

  assign in_stream.ready = in_ready;

endmodule

@@ hw/rtl/tuc_cfg_regs.sv @@
// Configuration register file: format, swizzle mode, image size and source pitch.
// Depends on tuc_pkg.
`timescale 1ns / 1ps

module tuc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tuc_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [tuc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output tuc_pkg::tuc_cfg_t                   cfg
);
  import tuc_pkg::*;

  tuc_cfg_t cfg_r;
  tuc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_PIXEL_FORMAT: cfg_nxt.fmt          = cfg_data[FMT_W-1:0];
        CFG_SWIZZLED:     cfg_nxt.swizzled     = cfg_data[0];
        CFG_IMAGE_WIDTH:  cfg_nxt.image_width  = cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_nxt.image_height = cfg_data[DIM_W-1:0];
        CFG_SOURCE_PITCH: cfg_nxt.source_pitch = cfg_data[PITCH_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fmt          <= FMT_RGB565;
      cfg_r.swizzled     <= 1'b0;
      cfg_r.image_width  <= RST_IMAGE_WIDTH;
      cfg_r.image_height <= RST_IMAGE_HEIGHT;
      cfg_r.source_pitch <= RST_SOURCE_PITCH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/tuc_walker.sv @@
// Block walker: decodes block geometry, tracks the position of each source element
// and holds the accepted beat in the input stage register. Depends on tuc_pkg.
`timescale 1ns / 1ps

module tuc_walker #(
  parameter int WW = 11,
  parameter int HW = 11,
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tuc_pkg::tuc_cfg_t               cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tuc_pkg::SRC_W-1:0]       in_element,
  output logic                            beat_valid,
  input  logic                            beat_ready,
  output tuc_pkg::tuc_beat_t              beat,
  output logic [WW-1:0]                   beat_col,
  output logic [HW-1:0]                   beat_row
);
  import tuc_pkg::*;

  logic [WW-1:0]  col_r, col_nxt, tcb_r, tcb_nxt;
  logic [HW-1:0]  row_r, row_nxt, trb_r, trb_nxt;
  logic [OFS_W-1:0] dst_r, dst_nxt;
  logic           s1_valid_r, s1_valid_nxt;
  tuc_beat_t      beat_r, beat_nxt;
  logic [WW-1:0]  col_out_r, col_out_nxt;
  logic [HW-1:0]  row_out_r, row_out_nxt;

  logic [WW-1:0]  w, tw, te, col_w, col_inc;
  logic [HW-1:0]  h, th, row_w, row_inc;
  logic [STRIDE_W-1:0] stride;
  logic [NB_W-1:0] nb;
  logic [WW:0]    tcb_sum;
  logic [HW:0]    trb_sum;
  logic [STRIDE_W+HW-1:0] band_prod;
  logic [OFS_W-1:0] dst_blk, dst_band;
  logic           accept, advance, last;

  // geometry
  always_comb begin
    if (cfg.image_width == '0) begin
      w = WW'(1);
    end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      h = HW'(1);
    end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(cfg.image_height);
    end
    th = cfg.swizzled ? HW'(TILE_ROWS) : h;
    if (cfg.fmt inside {[FMT_RGB565:FMT_ARGB4444]}) begin
      tw = (cfg.swizzled || w < WW'(TW16)) ? WW'(TW16) : w;
      te = tw;
    end else if (cfg.fmt == FMT_RGBA8888) begin
      tw = (cfg.swizzled || w < WW'(TW32)) ? WW'(TW32) : w;
      te = tw;
    end else if (cfg.fmt == FMT_INDEX4) begin
      tw = cfg.swizzled ? WW'(TW_IDX4)
                        : ((w + WW'(TW_IDX4 - 1)) & ~WW'(TW_IDX4 - 1));
      te = tw >> 1;
    end else begin
      tw = cfg.swizzled ? WW'(TW_IDX8)
                        : ((w + WW'(TW_IDX8 - 1)) & ~WW'(TW_IDX8 - 1));
      te = tw;
    end
    stride = tuc_stride(cfg.fmt, cfg.source_pitch);
    nb     = tuc_bytes(cfg.fmt);
  end

  // position advance
  always_comb begin
    in_ready = !s1_valid_r || beat_ready;
    accept   = in_valid && in_ready;
    advance  = s1_valid_r && beat_ready;

    col_w   = (col_r >= te) ? '0 : col_r;
    row_w   = (row_r >= th) ? '0 : row_r;
    col_inc = col_w + WW'(1);
    row_inc = row_w + HW'(1);
    tcb_sum = {1'b0, tcb_r} + {1'b0, tw};
    trb_sum = {1'b0, trb_r} + {1'b0, th};

    band_prod = stride * (th - HW'(1));
    dst_blk   = dst_r + tuc_scale(OFS_W'(te), nb);
    dst_band  = dst_blk + OFS_W'(band_prod);

    col_nxt = col_r;
    row_nxt = row_r;
    tcb_nxt = tcb_r;
    trb_nxt = trb_r;
    dst_nxt = dst_r;
    last    = 1'b0;
    if (accept) begin
      col_nxt = col_inc;
      row_nxt = row_w;
      if (col_inc >= te) begin
        col_nxt = '0;
        row_nxt = row_inc;
        if (row_inc >= th) begin
          row_nxt = '0;
          tcb_nxt = tcb_sum[WW-1:0];
          dst_nxt = dst_blk;
          if (tcb_sum >= {1'b0, w}) begin
            tcb_nxt = '0;
            trb_nxt = trb_sum[HW-1:0];
            dst_nxt = dst_band;
            if (trb_sum >= {1'b0, h}) begin
              trb_nxt = '0;
              dst_nxt = '0;
              last    = 1'b1;
            end
          end
        end
      end
    end

    s1_valid_nxt = accept || (s1_valid_r && !advance);
    beat_nxt     = beat_r;
    col_out_nxt  = col_out_r;
    row_out_nxt  = row_out_r;
    if (accept) begin
      beat_nxt.src_element = in_element;
      beat_nxt.fmt         = cfg.fmt;
      beat_nxt.stride      = stride;
      beat_nxt.nb          = nb;
      beat_nxt.dst_base    = dst_r;
      beat_nxt.last        = last;
      col_out_nxt          = col_w;
      row_out_nxt          = row_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      col_r      <= '0;
      row_r      <= '0;
      tcb_r      <= '0;
      trb_r      <= '0;
      dst_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      tcb_r      <= tcb_nxt;
      trb_r      <= trb_nxt;
      dst_r      <= dst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beat_r    <= beat_nxt;
    col_out_r <= col_out_nxt;
    row_out_r <= row_out_nxt;
  end

  assign beat_valid = s1_valid_r;
  assign beat       = beat_r;
  assign beat_col   = col_out_r;
  assign beat_row   = row_out_r;

endmodule

@@ hw/rtl/tuc_emit.sv @@
// Result stage: destination offset math and color expansion into the output register.
// Depends on tuc_pkg.
`timescale 1ns / 1ps

module tuc_emit #(
  parameter int WW = 11,
  parameter int HW = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          beat_valid,
  output logic                          beat_ready,
  input  tuc_pkg::tuc_beat_t            beat,
  input  logic [WW-1:0]                 beat_col,
  input  logic [HW-1:0]                 beat_row,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tuc_pkg::OFS_W-1:0]     out_offset,
  output logic [tuc_pkg::DATA_W-1:0]    out_data,
  output logic [tuc_pkg::NB_W-1:0]      out_bytes,
  output logic                          out_last
);
  import tuc_pkg::*;

  logic              out_valid_r, out_valid_nxt;
  logic [OFS_W-1:0]  offset_r, offset_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [NB_W-1:0]   bytes_r, bytes_nxt;
  logic              last_r, last_nxt;
  logic [STRIDE_W+HW-1:0] row_prod;
  logic              load;

  always_comb begin
    beat_ready    = !out_valid_r || out_ready;
    load          = beat_valid && beat_ready;
    out_valid_nxt = load || (out_valid_r && !out_ready);

    row_prod = beat.stride * beat_row;

    offset_nxt = offset_r;
    data_nxt   = data_r;
    bytes_nxt  = bytes_r;
    last_nxt   = last_r;
    if (load) begin
      offset_nxt = beat.dst_base + OFS_W'(row_prod) + tuc_scale(OFS_W'(beat_col), beat.nb);
      data_nxt   = tuc_expand(beat.fmt, beat.src_element);
      bytes_nxt  = beat.nb;
      last_nxt   = beat.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    offset_r <= offset_nxt;
    data_r   <= data_nxt;
    bytes_r  <= bytes_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_offset = offset_r;
  assign out_data   = data_r;
  assign out_bytes  = bytes_r;
  assign out_last   = last_r;

endmodule

@@ hw/rtl/tuc_checker.sv @@
// Port-level checks on the result channel, bound to the top level.
// Depends on tuc_pkg and texture_unswizzle_color_expand.
`timescale 1ns / 1ps

module tuc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tuc_pkg::OFS_W-1:0]     out_offset,
  input logic [tuc_pkg::DATA_W-1:0]    out_data,
  input logic [tuc_pkg::NB_W-1:0]      out_bytes,
  input logic                          out_last
);
  import tuc_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_offset) && $stable(out_data)
      && $stable(out_bytes) && $stable(out_last))
    else $error("stalled result beat changed");

  a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bytes == NB_INDEX || out_bytes == NB_RGB || out_bytes == NB_RGBA))
    else $error("bad byte count");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bytes != NB_INDEX || out_data[DATA_W-1:8] == '0)
      && (out_bytes != NB_RGB || out_data[DATA_W-1:24] == '0))
    else $error("unused result bytes not zero");

endmodule

bind texture_unswizzle_color_expand tuc_checker u_tuc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_stream.valid),
  .out_ready  (out_stream.ready),
  .out_offset (out_stream.dst_offset),
  .out_data   (out_stream.dst_data),
  .out_bytes  (out_stream.dst_bytes),
  .out_last   (out_stream.last_of_image)
);
